/* rtl/core/complex_arith_unit_defines.svh */
// Assertion macros used by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CAU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CAU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/cau_pkg.sv */
// Types, constants and saturation helpers for the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

   typedef enum logic [2:0] {
      KIND_ADD   = 3'd0,
      KIND_SUB   = 3'd1,
      KIND_MUL   = 3'd2,
      KIND_DIV   = 3'd3,
      KIND_CONJ  = 3'd4,
      KIND_NEG   = 3'd5,
      KIND_SQMAG = 3'd6,
      KIND_MAG   = 3'd7
   } kind_type;

   // quotient bits kept by the divider; larger quotients saturate anyway
   localparam int QUO_BITS   = 33;
   localparam int SQRT_STEPS = 32;

   typedef struct packed {
      logic        ov;
      logic [31:0] val;
   } sat_type;

   typedef struct packed {
      kind_type    kind;
      logic        ov;
      logic        dz;
      logic [31:0] res_re;
      logic [31:0] res_im;
      logic        neg_re;
      logic        neg_im;
      logic        big_re;
      logic        big_im;
      logic [63:0] num_re;
      logic [63:0] num_im;
      logic [63:0] den;
      logic [64:0] rem_re;
      logic [64:0] rem_im;
      logic [32:0] quo_re;
      logic [32:0] quo_im;
      logic [63:0] sq_n;
      logic [63:0] sq_res;
   } pipe_type;

   // sign and magnitude to saturated 32-bit two's complement
   function automatic sat_type sat_sm(input logic neg, input logic [63:0] mag);
      sat_type r;
      if (neg) begin
         if (mag > 64'h0000_0000_8000_0000) begin
            r.ov  = 1'b1;
            r.val = 32'h8000_0000;
         end else begin
            r.ov  = 1'b0;
            r.val = 32'(64'd0 - mag);
         end
      end else begin
         if (mag > 64'h0000_0000_7FFF_FFFF) begin
            r.ov  = 1'b1;
            r.val = 32'h7FFF_FFFF;
         end else begin
            r.ov  = 1'b0;
            r.val = mag[31:0];
         end
      end
      return r;
   endfunction

   function automatic sat_type sat_s33(input logic signed [32:0] v);
      logic signed [63:0] w;
      logic [63:0]        mag;
      w   = 64'(v);
      mag = w[63] ? (64'd0 - w) : w;
      return sat_sm(w[63], mag);
   endfunction

endpackage

`default_nettype wire

/* rtl/core/complex_arith_unit.sv */
// Complex arithmetic unit: Q-format add, sub, mul, div, conj, neg, |a|^2, |a|.
// Every kind takes the same path from request accept to rsp_valid, through the registers
//   capture, products, sums, divider setup, 33 divider stages, output register.
// Throughput: one request per cycle unless rsp stalls; every step is its own register stage.
// A stall on rsp freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_arith_unit_defines.svh"

module complex_arith_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_a_re,
   input  logic signed [31:0] req_a_im,
   input  logic signed [31:0] req_b_re,
   input  logic signed [31:0] req_b_im,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_res_re,
   output logic signed [31:0] rsp_res_im,
   output logic               rsp_overflow,
   output logic               rsp_div_zero
);
   import cau_pkg::*;

   // Division works on N = m * 2^FRAC_BITS. Quotient bits above QUO_BITS-1
   // are caught up front by comparing N >> QUO_BITS against the divisor.
   localparam int DIV_SHIFT = QUO_BITS - FRAC_BITS;
   localparam int DEN_W     = 64 + DIV_SHIFT;
   localparam int E_STAGES  = QUO_BITS;

   // Global advance: the pipe moves whenever the output slot is free or drains.
   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // ---------------------------------------------------------------- stage A
   // Request capture.
   logic               a_valid_ff;
   kind_type           a_kind_ff;
   logic signed [31:0] a_ar_ff, a_ai_ff, a_br_ff, a_bi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         a_kind_ff  <= kind_type'(req_kind);
         a_ar_ff    <= req_a_re;
         a_ai_ff    <= req_a_im;
         a_br_ff    <= req_b_re;
         a_bi_ff    <= req_b_im;
      end
   end

   // ---------------------------------------------------------------- stage B
   // Six 32x32 products; the magnitude kinds reuse the first two as squares.
   // The short kinds (add, sub, conj, neg) finish here.
   logic signed [31:0] mul1_b, mul2_b;
   logic signed [63:0] b_rr_in, b_ii_in, b_ri_in, b_ir_in, b_dr_in, b_di_in;
   logic signed [32:0] s_re, s_im;
   sat_type            s_sat_re, s_sat_im;
   logic               a_is_mag;

   assign a_is_mag = (a_kind_ff == KIND_SQMAG) || (a_kind_ff == KIND_MAG);
   assign mul1_b   = a_is_mag ? a_ar_ff : a_br_ff;
   assign mul2_b   = a_is_mag ? a_ai_ff : a_bi_ff;
   assign b_rr_in  = a_ar_ff * mul1_b;
   assign b_ii_in  = a_ai_ff * mul2_b;
   assign b_ri_in  = a_ar_ff * a_bi_ff;
   assign b_ir_in  = a_ai_ff * a_br_ff;
   assign b_dr_in  = a_br_ff * a_br_ff;
   assign b_di_in  = a_bi_ff * a_bi_ff;

   always_comb begin
      unique case (a_kind_ff)
         KIND_ADD: begin
            s_re = 33'(a_ar_ff) + 33'(a_br_ff);
            s_im = 33'(a_ai_ff) + 33'(a_bi_ff);
         end
         KIND_SUB: begin
            s_re = 33'(a_ar_ff) - 33'(a_br_ff);
            s_im = 33'(a_ai_ff) - 33'(a_bi_ff);
         end
         KIND_CONJ: begin
            s_re = 33'(a_ar_ff);
            s_im = -33'(a_ai_ff);
         end
         KIND_NEG: begin
            s_re = -33'(a_ar_ff);
            s_im = -33'(a_ai_ff);
         end
         default: begin
            s_re = '0;
            s_im = '0;
         end
      endcase
      s_sat_re = sat_s33(s_re);
      s_sat_im = sat_s33(s_im);
   end

   logic               b_valid_ff;
   kind_type           b_kind_ff;
   logic signed [63:0] b_rr_ff, b_ii_ff, b_ri_ff, b_ir_ff, b_dr_ff, b_di_ff;
   logic [31:0]        b_res_re_ff, b_res_im_ff;
   logic               b_ov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff  <= a_valid_ff;
         b_kind_ff   <= a_kind_ff;
         b_rr_ff     <= b_rr_in;
         b_ii_ff     <= b_ii_in;
         b_ri_ff     <= b_ri_in;
         b_ir_ff     <= b_ir_in;
         b_dr_ff     <= b_dr_in;
         b_di_ff     <= b_di_in;
         b_res_re_ff <= s_sat_re.val;
         b_res_im_ff <= s_sat_im.val;
         b_ov_ff     <= s_sat_re.ov | s_sat_im.ov;
      end
   end

   // ---------------------------------------------------------------- stage C
   // Exact sums of the products, kept as sign and magnitude.
   logic signed [64:0] c_sum_re, c_sum_im;
   logic [63:0]        c_mag_re_in, c_mag_im_in, c_den_in;

   always_comb begin
      unique case (b_kind_ff)
         KIND_MUL: begin
            c_sum_re = 65'(b_rr_ff) - 65'(b_ii_ff);
            c_sum_im = 65'(b_ri_ff) + 65'(b_ir_ff);
         end
         KIND_DIV: begin
            c_sum_re = 65'(b_rr_ff) + 65'(b_ii_ff);
            c_sum_im = 65'(b_ir_ff) - 65'(b_ri_ff);
         end
         default: begin
            c_sum_re = 65'(b_rr_ff) + 65'(b_ii_ff);
            c_sum_im = '0;
         end
      endcase
   end

   assign c_mag_re_in = c_sum_re[64] ? 64'(-c_sum_re) : 64'(c_sum_re);
   assign c_mag_im_in = c_sum_im[64] ? 64'(-c_sum_im) : 64'(c_sum_im);
   assign c_den_in    = $unsigned(b_dr_ff) + $unsigned(b_di_ff);

   logic        c_valid_ff;
   kind_type    c_kind_ff;
   logic        c_neg_re_ff, c_neg_im_ff;
   logic [63:0] c_mag_re_ff, c_mag_im_ff, c_den_ff;
   logic [31:0] c_res_re_ff, c_res_im_ff;
   logic        c_ov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff  <= b_valid_ff;
         c_kind_ff   <= b_kind_ff;
         c_neg_re_ff <= c_sum_re[64];
         c_neg_im_ff <= c_sum_im[64];
         c_mag_re_ff <= c_mag_re_in;
         c_mag_im_ff <= c_mag_im_in;
         c_den_ff    <= c_den_in;
         c_res_re_ff <= b_res_re_ff;
         c_res_im_ff <= b_res_im_ff;
         c_ov_ff     <= b_ov_ff;
      end
   end

   // ---------------------------------------------------------------- stage D
   // Mul and |a|^2 finish; divider and square root get their start values.
   pipe_type          d_in;
   sat_type           d_sat_re, d_sat_im;
   logic [DEN_W-1:0]  d_num_ext_re, d_num_ext_im, d_den_ext;

   assign d_num_ext_re = DEN_W'(c_mag_re_ff);
   assign d_num_ext_im = DEN_W'(c_mag_im_ff);
   assign d_den_ext    = DEN_W'(c_den_ff) << DIV_SHIFT;

   always_comb begin
      d_sat_re      = sat_sm(c_neg_re_ff && (c_kind_ff == KIND_MUL),
                             c_mag_re_ff >> FRAC_BITS);
      d_sat_im      = sat_sm(c_neg_im_ff, c_mag_im_ff >> FRAC_BITS);
      d_in.kind     = c_kind_ff;
      d_in.dz       = (c_kind_ff == KIND_DIV) && (c_den_ff == 64'd0);
      d_in.neg_re   = c_neg_re_ff;
      d_in.neg_im   = c_neg_im_ff;
      d_in.big_re   = d_num_ext_re >= d_den_ext;
      d_in.big_im   = d_num_ext_im >= d_den_ext;
      d_in.num_re   = c_mag_re_ff;
      d_in.num_im   = c_mag_im_ff;
      d_in.den      = c_den_ff;
      d_in.rem_re   = 65'(c_mag_re_ff >> DIV_SHIFT);
      d_in.rem_im   = 65'(c_mag_im_ff >> DIV_SHIFT);
      d_in.quo_re   = '0;
      d_in.quo_im   = '0;
      d_in.sq_n     = c_mag_re_ff;
      d_in.sq_res   = '0;
      unique case (c_kind_ff)
         KIND_MUL: begin
            d_in.res_re = d_sat_re.val;
            d_in.res_im = d_sat_im.val;
            d_in.ov     = d_sat_re.ov | d_sat_im.ov;
         end
         KIND_SQMAG: begin
            d_in.res_re = d_sat_re.val;
            d_in.res_im = '0;
            d_in.ov     = d_sat_re.ov;
         end
         default: begin
            d_in.res_re = c_res_re_ff;
            d_in.res_im = c_res_im_ff;
            d_in.ov     = c_ov_ff;
         end
      endcase
   end

   pipe_type              pipe_ff [E_STAGES+1];
   logic [E_STAGES:0]     pv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff[0] <= 1'b0;
      end else if (advance) begin
         pv_ff[0]   <= c_valid_ff;
         pipe_ff[0] <= d_in;
      end
   end

   // ---------------------------------------------------------------- stage E
   // One restoring-division bit per stage for both parts; the first
   // SQRT_STEPS stages also run one square-root step each.
   for (genvar k = 0; k < E_STAGES; k++) begin : g_stage
      localparam int QI = QUO_BITS - 1 - k;

      logic        nb_re, nb_im;
      logic [64:0] rr_re, rr_im, den_ext;
      logic [63:0] sq_n_nx, sq_res_nx;
      pipe_type    stage_in;

      if (QI >= FRAC_BITS) begin : g_nb
         assign nb_re = pipe_ff[k].num_re[QI-FRAC_BITS];
         assign nb_im = pipe_ff[k].num_im[QI-FRAC_BITS];
      end else begin : g_nb_zero
         assign nb_re = 1'b0;
         assign nb_im = 1'b0;
      end

      if (k < SQRT_STEPS) begin : g_sqrt
         localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
         logic [64:0] trial;
         assign trial = 65'(pipe_ff[k].sq_res) + 65'(SQ_BIT);
         always_comb begin
            if ({1'b0, pipe_ff[k].sq_n} >= trial) begin
               sq_n_nx   = pipe_ff[k].sq_n - trial[63:0];
               sq_res_nx = (pipe_ff[k].sq_res >> 1) + SQ_BIT;
            end else begin
               sq_n_nx   = pipe_ff[k].sq_n;
               sq_res_nx = pipe_ff[k].sq_res >> 1;
            end
         end
      end else begin : g_sqrt_idle
         assign sq_n_nx   = pipe_ff[k].sq_n;
         assign sq_res_nx = pipe_ff[k].sq_res;
      end

      assign rr_re   = {pipe_ff[k].rem_re[63:0], nb_re};
      assign rr_im   = {pipe_ff[k].rem_im[63:0], nb_im};
      assign den_ext = {1'b0, pipe_ff[k].den};

      always_comb begin
         stage_in = pipe_ff[k];
         if (rr_re >= den_ext) begin
            stage_in.rem_re = rr_re - den_ext;
            stage_in.quo_re = {pipe_ff[k].quo_re[31:0], 1'b1};
         end else begin
            stage_in.rem_re = rr_re;
            stage_in.quo_re = {pipe_ff[k].quo_re[31:0], 1'b0};
         end
         if (rr_im >= den_ext) begin
            stage_in.rem_im = rr_im - den_ext;
            stage_in.quo_im = {pipe_ff[k].quo_im[31:0], 1'b1};
         end else begin
            stage_in.rem_im = rr_im;
            stage_in.quo_im = {pipe_ff[k].quo_im[31:0], 1'b0};
         end
         stage_in.sq_n   = sq_n_nx;
         stage_in.sq_res = sq_res_nx;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pv_ff[k+1] <= 1'b0;
         end else if (advance) begin
            pv_ff[k+1]   <= pv_ff[k];
            pipe_ff[k+1] <= stage_in;
         end
      end
   end

   // ---------------------------------------------------------------- output
   // Div and |a| pick their saturated results; everything else is carried.
   pipe_type    fin;
   sat_type     f_div_re, f_div_im, f_mag;
   logic [31:0] rsp_res_re_in, rsp_res_im_in;
   logic        rsp_ov_in, rsp_dz_in;

   assign fin = pipe_ff[E_STAGES];

   always_comb begin
      f_div_re = sat_sm(fin.neg_re, fin.big_re ? '1 : 64'(fin.quo_re));
      f_div_im = sat_sm(fin.neg_im, fin.big_im ? '1 : 64'(fin.quo_im));
      f_mag    = sat_sm(1'b0, fin.sq_res);
      unique case (fin.kind)
         KIND_DIV: begin
            if (fin.dz) begin
               rsp_res_re_in = '0;
               rsp_res_im_in = '0;
               rsp_ov_in     = 1'b0;
               rsp_dz_in     = 1'b1;
            end else begin
               rsp_res_re_in = f_div_re.val;
               rsp_res_im_in = f_div_im.val;
               rsp_ov_in     = f_div_re.ov | f_div_im.ov;
               rsp_dz_in     = 1'b0;
            end
         end
         KIND_MAG: begin
            rsp_res_re_in = f_mag.val;
            rsp_res_im_in = '0;
            rsp_ov_in     = f_mag.ov;
            rsp_dz_in     = 1'b0;
         end
         default: begin
            rsp_res_re_in = fin.res_re;
            rsp_res_im_in = fin.res_im;
            rsp_ov_in     = fin.ov;
            rsp_dz_in     = 1'b0;
         end
      endcase
   end

   kind_type    rsp_kind_ff;
   logic [31:0] rsp_res_re_ff, rsp_res_im_ff;
   logic        rsp_ov_ff, rsp_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff  <= pv_ff[E_STAGES];
         rsp_kind_ff   <= fin.kind;
         rsp_res_re_ff <= rsp_res_re_in;
         rsp_res_im_ff <= rsp_res_im_in;
         rsp_ov_ff     <= rsp_ov_in;
         rsp_dz_ff     <= rsp_dz_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_re   = rsp_res_re_ff;
   assign rsp_res_im   = rsp_res_im_ff;
   assign rsp_overflow = rsp_ov_ff;
   assign rsp_div_zero = rsp_dz_ff;

   // ------------------------------------------------------------ assertions
   `CAU_ASSERT_NXT(a_hold_pipe, clock, reset, !advance,
      $stable(pv_ff) && $stable(a_valid_ff) && $stable(rsp_valid_ff),
      "pipeline moved while stalled")
   `CAU_ASSERT_IMP(a_dz_kind, clock, reset, rsp_valid_ff && rsp_dz_ff,
      rsp_kind_ff == KIND_DIV && !rsp_ov_ff && rsp_res_re_ff == 32'd0 &&
      rsp_res_im_ff == 32'd0, "div_zero outside a zero-divisor division")
   `CAU_ASSERT_IMP(a_mag_im, clock, reset,
      rsp_valid_ff && (rsp_kind_ff == KIND_SQMAG || rsp_kind_ff == KIND_MAG),
      rsp_res_im_ff == 32'd0, "magnitude result with nonzero imaginary part")

endmodule

`default_nettype wire

/* tb/complex_arith_unit_checker.sv */
// Checker for the complex arithmetic unit: predicts each result and compares it.
`timescale 1ns / 1ps

module complex_arith_unit_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_a_re,
   input  logic signed [31:0] req_a_im,
   input  logic signed [31:0] req_b_re,
   input  logic signed [31:0] req_b_im,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_res_re,
   input  logic signed [31:0] rsp_res_im,
   input  logic               rsp_overflow,
   input  logic               rsp_div_zero,
   output int                 fail_count,
   output int                 pending
);
   import cau_pkg::*;

   typedef struct {
      logic [31:0] re;
      logic [31:0] im;
      logic        ov;
      logic        dz;
   } cplx_result_type;

   cplx_result_type results_due[$];

   // clamp a sign/magnitude value into 32-bit two's complement
   function automatic logic [31:0] clamp_sm(input logic neg, input logic [63:0] mag,
                                            inout logic ov);
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            ov = 1'b1;
            return 32'h8000_0000;
         end
         return 32'(64'd0 - mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
         ov = 1'b1;
         return 32'h7FFF_FFFF;
      end
      return mag[31:0];
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [31:0] clamp_int(input logic signed [63:0] v, inout logic ov);
      return clamp_sm(v < 0, abs64(v), ov);
   endfunction

   // signed sum of two products, kept as sign and magnitude
   function automatic logic [63:0] sum_mag(input logic signed [63:0] p,
                                           input logic signed [63:0] q, output logic neg);
      logic [63:0] mp, mq;
      mp = abs64(p);
      mq = abs64(q);
      if ((p < 0) == (q < 0)) begin
         neg = p < 0;
         return mp + mq;
      end
      if (mp >= mq) begin
         neg = (p < 0) && mp != mq;
         return mp - mq;
      end
      neg = q < 0;
      return mq - mp;
   endfunction

   // floor(m * 2^FRAC_BITS / d), capped just above the 32-bit range
   function automatic logic [63:0] frac_quotient(input logic [63:0] m, input logic [63:0] d);
      logic [63:0] q, r;
      q = m / d;
      r = m % d;
      for (int i = 0; i < FRAC_BITS; i++) begin
         if (q > 64'h1_0000_0000) return 64'h1_0000_0001;
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q[0] = 1'b1;
         end
      end
      if (q > 64'h1_0000_0000) return 64'h1_0000_0001;
      return q;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic cplx_result_type predict_result(input kind_type kind,
         input logic signed [31:0] ar32, input logic signed [31:0] ai32,
         input logic signed [31:0] br32, input logic signed [31:0] bi32);
      cplx_result_type r;
      logic signed [63:0] ar, ai, br, bi;
      logic [63:0] m, d;
      logic neg;
      ar = ar32;
      ai = ai32;
      br = br32;
      bi = bi32;
      r = '{re: 0, im: 0, ov: 0, dz: 0};
      case (kind)
         KIND_ADD: begin
            r.re = clamp_int(ar + br, r.ov);
            r.im = clamp_int(ai + bi, r.ov);
         end
         KIND_SUB: begin
            r.re = clamp_int(ar - br, r.ov);
            r.im = clamp_int(ai - bi, r.ov);
         end
         KIND_MUL: begin
            m = sum_mag(ar * br, -(ai * bi), neg);
            r.re = clamp_sm(neg, m >> FRAC_BITS, r.ov);
            m = sum_mag(ar * bi, ai * br, neg);
            r.im = clamp_sm(neg, m >> FRAC_BITS, r.ov);
         end
         KIND_DIV: begin
            d = abs64(br) * abs64(br) + abs64(bi) * abs64(bi);
            if (d == 0) begin
               r.dz = 1'b1;
            end else begin
               m = sum_mag(ar * br, ai * bi, neg);
               r.re = clamp_sm(neg, frac_quotient(m, d), r.ov);
               m = sum_mag(ai * br, -(ar * bi), neg);
               r.im = clamp_sm(neg, frac_quotient(m, d), r.ov);
            end
         end
         KIND_CONJ: begin
            r.re = ar32;
            r.im = clamp_int(-ai, r.ov);
         end
         KIND_NEG: begin
            r.re = clamp_int(-ar, r.ov);
            r.im = clamp_int(-ai, r.ov);
         end
         KIND_SQMAG: begin
            m = abs64(ar) * abs64(ar) + abs64(ai) * abs64(ai);
            r.re = clamp_sm(1'b0, m >> FRAC_BITS, r.ov);
         end
         default: begin
            m = abs64(ar) * abs64(ar) + abs64(ai) * abs64(ai);
            r.re = clamp_sm(1'b0, int_sqrt(m), r.ov);
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      cplx_result_type want;
      if (reset) begin
         results_due.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            results_due.push_back(predict_result(kind_type'(req_kind), req_a_re,
                                                 req_a_im, req_b_re, req_b_im));
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $error("unexpected response re=%0d im=%0d", rsp_res_re, rsp_res_im);
               fail_count <= fail_count + 1;
            end else begin
               want = results_due.pop_front();
               if (rsp_res_re !== want.re || rsp_res_im !== want.im ||
                   rsp_overflow !== want.ov || rsp_div_zero !== want.dz)
                  fail_count <= fail_count + 1;
               if (rsp_res_re !== want.re)
                  $error("res_re expected %0d got %0d", $signed(want.re), rsp_res_re);
               if (rsp_res_im !== want.im)
                  $error("res_im expected %0d got %0d", $signed(want.im), rsp_res_im);
               if (rsp_overflow !== want.ov)
                  $error("overflow expected %0b got %0b", want.ov, rsp_overflow);
               if (rsp_div_zero !== want.dz)
                  $error("div_zero expected %0b got %0b", want.dz, rsp_div_zero);
            end
         end
      end
      pending <= results_due.size();
   end

endmodule

/* tb/complex_arith_unit_tb.sv */
// Testbench top for the complex arithmetic unit: stimulus, handshake pacing, verdict.
`timescale 1ns / 1ps

module complex_arith_unit_tb;
   import cau_pkg::*;

   localparam int  LATENCY     = 37;
   localparam int  RANDOM_REQS = 1000;
   localparam int  HOLD_CYCLES = 300;
   localparam longint CYCLE_LIMIT = 400000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_kind;
   logic signed [31:0] req_a_re, req_a_im, req_b_re, req_b_im;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_res_re, rsp_res_im;
   logic               rsp_overflow, rsp_div_zero;
   int                 fail_count;
   int                 pending;

   // idle percentages per phase; phase 2 runs with no idling at all
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_rsp;        // long receiver hold-off, set by its own process
   longint cycle_count;

   complex_arith_unit dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_kind,
      .req_a_re, .req_a_im, .req_b_re, .req_b_im,
      .rsp_valid, .rsp_stall,
      .rsp_res_re, .rsp_res_im, .rsp_overflow, .rsp_div_zero
   );

   complex_arith_unit_checker checker_i (
      .clock, .reset,
      .req_valid, .req_stall, .req_kind,
      .req_a_re, .req_a_im, .req_b_re, .req_b_im,
      .rsp_valid, .rsp_stall,
      .rsp_res_re, .rsp_res_im, .rsp_overflow, .rsp_div_zero,
      .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // timeout watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // receiver stall, redrawn each falling edge
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
   end

   // operand values that favor the edges of the Q16.16 range
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'd0;
         3: return 32'($signed($urandom_range(8)) - 4) <<< 16;
         4, 5: return 32'($signed($urandom_range(2000000)) - 1000000);
         default: return $urandom();
      endcase
   endfunction

   // one request; waits for acceptance at a rising edge
   task automatic send_request(input kind_type kind, input logic [31:0] ar,
                               input logic [31:0] ai, input logic [31:0] br,
                               input logic [31:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_a_re  <= ar;
      req_a_im  <= ai;
      req_b_re  <= br;
      req_b_im  <= bi;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_random_request();
      kind_type kind;
      logic [31:0] br, bi;
      kind = kind_type'($urandom_range(7));
      br = pick_operand();
      bi = pick_operand();
      // a zero divisor now and then
      if (kind == KIND_DIV && $urandom_range(9) == 0) begin
         br = 0;
         bi = 0;
      end
      send_request(kind, pick_operand(), pick_operand(), br, bi);
   endtask

   initial begin
      reset         = 1'b1;
      hold_rsp      = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      rsp_stall     = 1'b0;
      req_valid     = 1'b0;
      req_kind      = KIND_ADD;
      req_a_re      = 0;
      req_a_im      = 0;
      req_b_re      = 0;
      req_b_im      = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every kind, range extremes, saturation, zero divisor, unary kinds
      send_request(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF);
      send_request(KIND_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
      send_request(KIND_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF);
      send_request(KIND_SUB, 32'h0005_0000, 32'd0, 32'h0002_8000, 32'h0001_0000);
      send_request(KIND_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
      send_request(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_request(KIND_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(KIND_DIV, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0);
      send_request(KIND_DIV, 32'h0006_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
      send_request(KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd0);
      send_request(KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_request(KIND_DIV, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(KIND_CONJ, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1234_5678);
      send_request(KIND_CONJ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0);
      send_request(KIND_NEG, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(KIND_NEG, 32'h0001_0000, 32'hFFFF_0000, 32'd5, 32'd6);
      send_request(KIND_SQMAG, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_FFFF, 32'd0);
      send_request(KIND_SQMAG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
      send_request(KIND_MAG, 32'h0003_0000, 32'hFFFC_0000, 32'd0, 32'hFFFF_FFFF);
      send_request(KIND_MAG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
      send_request(KIND_MAG, 32'd0, 32'd0, 32'd0, 32'd0);
      send_request(KIND_MAG, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0);

      // long receiver hold-off while requests keep coming, so the pipe backs up
      fork
         begin
            hold_rsp = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         repeat (80) send_random_request();
      join

      // random part in three pacing phases
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 46 : 0;
         recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 18 : 0;
         repeat (RANDOM_REQS / 3) send_random_request();
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cau_pkg.sv
rtl/core/complex_arith_unit.sv
tb/complex_arith_unit_checker.sv
tb/complex_arith_unit_tb.sv
